// ===== design/mlsalu_pkg.sv =====
// Shared types and codes for the limb-serial multiprecision ALU.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mlsalu_pkg;

  // Operation codes carried in the action field
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // Status codes reported on the last limb
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CARRY    = 2'd1;
  localparam logic [1:0] ST_MUL_OVF  = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO = 2'd3;

  // Input item
  typedef struct packed {
    logic [1:0]  action;
    logic        first_limb;
    logic        last_limb;
    logic [31:0] dest_limb;
    logic [31:0] src_limb;
    logic [31:0] factor;
  } in_t;

  // Result item
  typedef struct packed {
    logic [31:0] result_limb;
    logic        result_last;
    logic [1:0]  status;
  } out_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture the input item
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic commit;     // write result register, update running carry
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_run;    // item is a divide by a nonzero factor
    logic div_last;   // final quotient bit this cycle
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ===== design/multiprecision_limb_serial_alu_core.sv =====
// Limb-serial multiprecision ALU, one result limb per input limb.
// Add, subtract, multiply and divide by zero go from the setup state to the done state;
// a divide by a nonzero factor also runs the restoring divider, one quotient bit per
// cycle, over LIMB_BITS bits (2*LIMB_BITS when the carried remainder is not below the
// factor). The result is registered on commit, and a new input is not accepted until
// the current item has committed. Output stalls hold the item in flight.
`default_nettype none

module multiprecision_limb_serial_alu_core #(
  parameter int LIMB_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mlsalu_pkg::in_t   in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mlsalu_pkg::out_t       out_data
);

  // Synchronous active-low reset clears the controller state, running carry and result valid.
  mlsalu_pkg::cmd_t cmd;
  mlsalu_pkg::sts_t sts;

  mlsalu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlsalu_dp #(
    .LIMB_BITS (LIMB_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/mlsalu_ctrl.sv =====
// Controller state machine for the limb-serial ALU.
// Depends on mlsalu_pkg for state, command and status types.
`default_nettype none

module mlsalu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mlsalu_pkg::sts_t  sts,
  output mlsalu_pkg::cmd_t       cmd
);

  mlsalu_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlsalu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      mlsalu_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = mlsalu_pkg::S_SETUP;
        end
      end
      mlsalu_pkg::S_SETUP: begin
        if (sts.div_run) begin
          cmd.div_start = 1'b1;
          state_nxt     = mlsalu_pkg::S_DIV;
        end else begin
          state_nxt = mlsalu_pkg::S_DONE;
        end
      end
      mlsalu_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = mlsalu_pkg::S_DONE;
        end
      end
      mlsalu_pkg::S_DONE: begin
        // wait for the result register to drain
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = mlsalu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mlsalu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/mlsalu_dp.sv =====
// Datapath for the limb-serial ALU: operand latch, running carry,
// restoring divider, add/sub/multiply logic and result register.
// Depends on mlsalu_pkg for payload, command and status types.
`default_nettype none

module mlsalu_dp #(
  parameter int LIMB_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mlsalu_pkg::in_t   in_data,
  input  wire mlsalu_pkg::cmd_t  cmd,
  output mlsalu_pkg::sts_t       sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mlsalu_pkg::out_t       out_data
);

  localparam int LB = LIMB_BITS;
  localparam int CW = $clog2(2 * LB + 1);

  mlsalu_pkg::in_t   op_r;
  logic [LB-1:0]     carry_r;
  logic [LB-1:0]     rem_r;
  logic [2*LB-1:0]   sh_r;
  logic [LB-1:0]     q_r;
  logic [CW-1:0]     cnt_r;
  mlsalu_pkg::out_t  out_r;
  logic              out_valid_r;

  // Masked operands and effective carry
  logic [LB-1:0] d, s, f, c_eff;
  assign d     = op_r.dest_limb[LB-1:0];
  assign s     = op_r.src_limb[LB-1:0];
  assign f     = op_r.factor[LB-1:0];
  assign c_eff = op_r.first_limb ? '0 : carry_r;

  // Operand latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_data;
    end
  end

  // Divider: one quotient bit per cycle
  logic [LB:0]   trial;
  logic          ge;
  logic [LB:0]   trial_sub;
  assign trial     = {rem_r, sh_r[2*LB-1]};
  assign ge        = trial >= {1'b0, f};
  assign trial_sub = trial - {1'b0, f};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      if (c_eff < f) begin
        // remainder already below divisor: only the low limb's bits remain
        rem_r <= c_eff;
        sh_r  <= {d, {LB{1'b0}}};
        cnt_r <= CW'(LB);
      end else begin
        rem_r <= '0;
        sh_r  <= {c_eff, d};
        cnt_r <= CW'(2 * LB);
      end
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[LB-1:0] : trial[LB-1:0];
      sh_r  <= {sh_r[2*LB-2:0], 1'b0};
      q_r   <= {q_r[LB-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign sts.div_run  = (op_r.action == mlsalu_pkg::ACT_DIV) && (f != '0);
  assign sts.div_last = (cnt_r == CW'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  // Result selection
  logic [LB+1:0]   sum;
  logic [LB:0]     need;
  logic [LB+1:0]   diff;
  logic [2*LB-1:0] prod;
  logic [LB-1:0]   res;
  logic [LB-1:0]   c_new;
  logic [1:0]      st;

  assign sum  = {2'b00, d} + {2'b00, s} + {2'b00, c_eff};
  assign need = {1'b0, s} + {1'b0, c_eff};
  assign diff = {2'b00, d} - {1'b0, need};
  assign prod = {{LB{1'b0}}, f} * {{LB{1'b0}}, d} + {{LB{1'b0}}, c_eff};

  always_comb begin
    res   = '0;
    c_new = '0;
    st    = mlsalu_pkg::ST_OK;
    case (op_r.action)
      mlsalu_pkg::ACT_ADD: begin
        res   = sum[LB-1:0];
        c_new = LB'(sum[LB+1:LB]);
        if (op_r.last_limb && (c_new != '0)) begin
          st = mlsalu_pkg::ST_CARRY;
        end
      end
      mlsalu_pkg::ACT_SUB: begin
        res   = diff[LB-1:0];
        c_new = LB'({{LB{1'b0}}, ({1'b0, d} < need)});
        if (op_r.last_limb && (c_new != '0)) begin
          st = mlsalu_pkg::ST_CARRY;
        end
      end
      mlsalu_pkg::ACT_MUL: begin
        res   = prod[LB-1:0];
        c_new = prod[2*LB-1:LB];
        if (op_r.last_limb && (c_new != '0)) begin
          st = mlsalu_pkg::ST_MUL_OVF;
        end
      end
      default: begin
        if (f == '0) begin
          if (op_r.last_limb) begin
            st = mlsalu_pkg::ST_DIV_ZERO;
          end
        end else begin
          res   = q_r;
          c_new = rem_r;
        end
      end
    endcase
  end

  // Running carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else if (cmd.commit) begin
      carry_r <= c_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.result_limb <= 32'(res);
      out_r.result_last <= op_r.last_limb;
      out_r.status      <= st;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== verif/multiprecision_limb_serial_alu_core_test.sv =====
// Self-checking bench for the limb-serial multiprecision ALU core.
// Needs mlsalu_pkg and multiprecision_limb_serial_alu_core; predicts each result limb
// from its own running-carry model and checks the out channel in order.
`timescale 1ns / 1ps

module multiprecision_limb_serial_alu_core_test;

  localparam int          LIMB_BITS  = 32;
  localparam logic [63:0] LIMB_MASK  = (64'd1 << LIMB_BITS) - 64'd1;
  localparam logic [31:0] LIMB_MAX   = 32'hFFFF_FFFF;
  localparam int          RAND_ITEMS = 1800;
  localparam int          STALL_MAX  = 2000;  // cycles with no transfer at all
  localparam int          DRAIN_WAIT = 100;   // extra wait after the last expected result
  localparam int          HOLD_LEN   = 300;   // long receiver hold-off

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mlsalu_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mlsalu_pkg::out_t out_data;

  mlsalu_pkg::in_t  pending_limbs[$];
  mlsalu_pkg::out_t expected_limbs[$];
  logic [31:0] limb_carry = '0;
  int          in_count = 0;
  int          fail_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          quiet_cycles = 0;

  multiprecision_limb_serial_alu_core #(.LIMB_BITS(LIMB_BITS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected result for one limb; advances the running carry/borrow/remainder
  function automatic mlsalu_pkg::out_t predict_limb(mlsalu_pkg::in_t it);
    logic [63:0] d, s, f, c, acc, need, res;
    mlsalu_pkg::out_t r;
    d   = {32'd0, it.dest_limb} & LIMB_MASK;
    s   = {32'd0, it.src_limb} & LIMB_MASK;
    f   = {32'd0, it.factor} & LIMB_MASK;
    res = '0;
    r.status      = mlsalu_pkg::ST_OK;
    r.result_last = it.last_limb;
    if (it.first_limb) limb_carry = '0;
    c = {32'd0, limb_carry} & LIMB_MASK;
    case (it.action)
      mlsalu_pkg::ACT_ADD: begin
        acc = d + s + c;
        res = acc & LIMB_MASK;
        c   = acc >> LIMB_BITS;
        if (it.last_limb && c != 0) r.status = mlsalu_pkg::ST_CARRY;
      end
      mlsalu_pkg::ACT_SUB: begin
        need = s + c;
        if (d < need) begin
          res = (d + LIMB_MASK + 64'd1 - need) & LIMB_MASK;
          c   = 64'd1;
        end else begin
          res = d - need;
          c   = 64'd0;
        end
        if (it.last_limb && c != 0) r.status = mlsalu_pkg::ST_CARRY;
      end
      mlsalu_pkg::ACT_MUL: begin
        acc = f * d + c;
        res = acc & LIMB_MASK;
        c   = acc >> LIMB_BITS;
        if (it.last_limb && c != 0) r.status = mlsalu_pkg::ST_MUL_OVF;
      end
      default: begin
        if (f == 0) begin
          res = '0;
          c   = '0;
          if (it.last_limb) r.status = mlsalu_pkg::ST_DIV_ZERO;
        end else begin
          // quotient may overflow a limb when the carry came from another op
          acc = (c << LIMB_BITS) + d;
          res = (acc / f) & LIMB_MASK;
          c   = acc % f;
        end
      end
    endcase
    limb_carry    = c[31:0] & LIMB_MASK[31:0];
    r.result_limb = res[31:0];
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones; quiet windows have none
  function automatic int idle_cycles();
    int r;
    if (((in_count / 150) % 5) == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Limb values weighted toward the edges so carries and borrows happen often
  function automatic logic [31:0] pick_limb();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LIMB_MAX;
      2:       return $urandom_range(0, 15);
      3:       return LIMB_MAX - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 15))
      0:          return '0;
      1:          return 32'd1;
      2:          return LIMB_MAX;
      3, 4:       return $urandom;
      5:          return LIMB_MAX - $urandom_range(0, 255);
      default:    return $urandom_range(2, 1000);
    endcase
  endfunction

  task automatic queue_limb(input logic [1:0] act, input logic first, input logic last,
                            input logic [31:0] d, input logic [31:0] s,
                            input logic [31:0] f);
    mlsalu_pkg::in_t it;
    it.action     = act;
    it.first_limb = first;
    it.last_limb  = last;
    it.dest_limb  = d;
    it.src_limb   = s;
    it.factor     = f;
    pending_limbs.push_back(it);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Sender: offers the next pending limb, holds it until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_limbs.push_back(predict_limb(in_data));
        in_count <= in_count + 1;
      end
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_limbs.size() != 0) begin
        in_data  <= pending_limbs.pop_front();
        in_valid <= 1'b1;
        send_gap <= idle_cycles();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, so the core fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 400) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks each result transfer against the oldest expectation
  always @(posedge clk) begin : recv_side
    int               nxt;
    mlsalu_pkg::out_t want;
    nxt = recv_gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_limbs.size() == 0) begin
          note_failure($sformatf("unexpected result: limb %h last %b status %0d",
                                 out_data.result_limb, out_data.result_last,
                                 out_data.status));
        end else begin
          want = expected_limbs.pop_front();
          if (out_data.result_limb !== want.result_limb ||
              out_data.result_last !== want.result_last ||
              out_data.status !== want.status)
            note_failure($sformatf(
              "mismatch: expected limb %h last %b status %0d, got limb %h last %b status %0d",
              want.result_limb, want.result_last, want.status,
              out_data.result_limb, out_data.result_last, out_data.status));
        end
        nxt = idle_cycles();
      end else if (nxt != 0) begin
        nxt = nxt - 1;
      end
      recv_gap  <= nxt;
      out_ready <= (nxt == 0) && (hold_left == 0);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("timeout: no transfer for %0d cycles", STALL_MAX);
      $display("** multiprecision_limb_serial_alu_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int          made;
    int          len;
    logic [1:0]  act;
    logic [31:0] fac;

    // add: max + max carries out; plain zero; carry across two limbs
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b1, 1'b1, LIMB_MAX, LIMB_MAX, '0);
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b1, 1'b1, '0, '0, LIMB_MAX);
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b1, 1'b0, LIMB_MAX, 32'd1, '0);
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b0, 1'b1, '0, '0, '0);
    // subtract: borrow out, equal operands, borrow chain to the last limb
    queue_limb(mlsalu_pkg::ACT_SUB, 1'b1, 1'b1, '0, 32'd1, '0);
    queue_limb(mlsalu_pkg::ACT_SUB, 1'b1, 1'b1, LIMB_MAX, LIMB_MAX, '0);
    queue_limb(mlsalu_pkg::ACT_SUB, 1'b1, 1'b0, '0, 32'd1, '0);
    queue_limb(mlsalu_pkg::ACT_SUB, 1'b0, 1'b1, '0, LIMB_MAX, '0);
    // multiply: overflow at max, zero factor, carry into the next limb
    queue_limb(mlsalu_pkg::ACT_MUL, 1'b1, 1'b1, LIMB_MAX, '0, LIMB_MAX);
    queue_limb(mlsalu_pkg::ACT_MUL, 1'b1, 1'b1, LIMB_MAX, LIMB_MAX, '0);
    queue_limb(mlsalu_pkg::ACT_MUL, 1'b1, 1'b0, 32'h8000_0000, '0, 32'd2);
    queue_limb(mlsalu_pkg::ACT_MUL, 1'b0, 1'b1, '0, '0, 32'd2);
    // divide by zero on an inner limb, then on the last limb
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b1, 1'b0, LIMB_MAX, '0, '0);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b0, 1'b1, 32'd5, '0, '0);
    // divide most significant limb first, by max and by 7, and by one
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b1, 1'b0, LIMB_MAX, '0, LIMB_MAX);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b0, 1'b1, 32'd5, '0, LIMB_MAX);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b1, 1'b0, 32'd6, '0, 32'd7);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b0, 1'b0, LIMB_MAX, '0, 32'd7);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b0, 1'b1, 32'h1234_5678, '0, 32'd7);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b1, 1'b1, LIMB_MAX, LIMB_MAX, 32'd1);
    // mixed ops: big multiply carry feeds a divide whose quotient overflows
    queue_limb(mlsalu_pkg::ACT_MUL, 1'b1, 1'b0, LIMB_MAX, '0, LIMB_MAX);
    queue_limb(mlsalu_pkg::ACT_DIV, 1'b0, 1'b1, LIMB_MAX, '0, 32'd3);
    // carry survives a last limb and a missing first mark
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b1, 1'b1, LIMB_MAX, 32'd1, '0);
    queue_limb(mlsalu_pkg::ACT_ADD, 1'b0, 1'b1, '0, '0, '0);
    queue_limb(mlsalu_pkg::ACT_SUB, 1'b0, 1'b1, 32'd3, LIMB_MAX, '0);

    // Random part: mostly well-formed numbers, the rest loose limbs
    made = 0;
    while (made < RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        act = 2'($urandom_range(0, 3));
        fac = pick_factor();
        for (int i = 0; i < len; i++)
          queue_limb(act, i == 0, i == len - 1, pick_limb(), pick_limb(), fac);
        made += len;
      end else begin
        queue_limb(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), pick_limb(), pick_limb(), pick_factor());
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_limbs.size() != 0 || in_valid) @(posedge clk);
    while (expected_limbs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("** multiprecision_limb_serial_alu_core: PASSED **");
    end else begin
      $display("** multiprecision_limb_serial_alu_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mlsalu_pkg.sv
design/mlsalu_ctrl.sv
design/mlsalu_dp.sv
design/multiprecision_limb_serial_alu_core.sv
verif/multiprecision_limb_serial_alu_core_test.sv
